>>> rtl/c3rb_pkg.sv
// Shared constants, types and helpers of the 3x3 replicate-border convolution block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package c3rb_pkg;

    // Sizing
    localparam int MAX_WIDTH     = 1024;
    localparam int PIX_W         = 16;
    localparam int COEF_W        = 16;
    localparam int COL_W         = $clog2(MAX_WIDTH);

    // Fixed field widths
    localparam int ROW_W         = 16;
    localparam int OUT_COL_W     = 10;
    localparam int WIDTH_REG_W   = 11;
    localparam int HEIGHT_REG_W  = 16;
    localparam int PIXEL_FIELD_W = 16;
    localparam int CMD_W         = 1;
    localparam int COEF_SLOT_W   = 16;
    localparam int KROW_W        = 3 * COEF_SLOT_W;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 48;
    localparam int VALUE_W       = 35;

    // Datapath growth
    localparam int PROD_W        = PIX_W + COEF_W;
    localparam int RSUM_W        = PROD_W + 2;
    localparam int SUM_W         = PROD_W + 4;

    // Result queue (power of two so the pointers wrap on their own)
    localparam int FIFO_DEPTH    = 16;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int USED_W        = $clog2(FIFO_DEPTH + 1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PIXEL = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd4;

    typedef logic [1:0]              t_slot;
    typedef logic signed [PIX_W-1:0] t_pix;
    typedef logic [3*PIX_W-1:0]      t_colword;   // one column, three row slots
    typedef logic [9*PIX_W-1:0]      t_taps;      // tap 3*row+col
    typedef logic [2:0][KROW_W-1:0]  t_kernel;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 last_in_run;
        logic                 last_of_frame;
    } t_tag;

    typedef struct packed {
        logic valid;
        t_tag tag;
    } t_mac_ctl;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        t_tag                      tag;
    } t_result;

    function automatic t_slot slot_next(t_slot s);
        return (s == 2'd2) ? 2'd0 : 2'(s + 2'd1);
    endfunction

    function automatic t_slot slot_prev(t_slot s);
        return (s == 2'd0) ? 2'd2 : 2'(s - 2'd1);
    endfunction

endpackage

>>> rtl/c3rb_ifs.sv
// Channel interfaces: pixel requests in, results out, register writes.
// Depends on c3rb_pkg for field widths.
`timescale 1ns / 1ps

interface c3rb_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [c3rb_pkg::CMD_W-1:0]           command;
    logic signed [c3rb_pkg::PIXEL_FIELD_W-1:0] pixel;

    modport source (output valid, command, pixel, input ready);
    modport sink   (input valid, command, pixel, output ready);
endinterface

interface c3rb_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [c3rb_pkg::VALUE_W-1:0]  value;
    logic [c3rb_pkg::ROW_W-1:0]           out_row;
    logic [c3rb_pkg::OUT_COL_W-1:0]       out_col;
    logic                                 last_in_run;
    logic                                 last_of_frame;

    modport source (output valid, value, out_row, out_col, last_in_run, last_of_frame,
                    input ready);
    modport sink   (input valid, value, out_row, out_col, last_in_run, last_of_frame,
                    output ready);
endinterface

interface c3rb_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [c3rb_pkg::CFG_IDX_W-1:0]       index;
    logic [c3rb_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/c3rb_mac.sv
// Nine-tap multiply-accumulate pipeline: taps, products, row sums, total.
// Depends on c3rb_pkg. Four register stages, one result per cycle.
`timescale 1ns / 1ps

module c3rb_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  c3rb_pkg::t_mac_ctl  i_ctl,
    input  c3rb_pkg::t_taps     i_taps,
    input  c3rb_pkg::t_kernel   i_kernel,
    output c3rb_pkg::t_mac_ctl  o_ctl,
    output logic signed [c3rb_pkg::VALUE_W-1:0] o_value
);

    c3rb_pkg::t_mac_ctl r_s0_ctl, r_s1_ctl, r_s2_ctl, r_s3_ctl;
    c3rb_pkg::t_taps    r_s0_taps;
    logic signed [c3rb_pkg::PROD_W-1:0] r_s1_prod [9];
    logic signed [c3rb_pkg::PROD_W-1:0] n_prod    [9];
    logic signed [c3rb_pkg::RSUM_W-1:0] r_s2_row  [3];
    logic signed [c3rb_pkg::RSUM_W-1:0] n_row     [3];
    logic signed [c3rb_pkg::SUM_W-1:0]  n_sum;
    logic signed [c3rb_pkg::VALUE_W-1:0] r_s3_value;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                n_prod[3*a+b] =
                    c3rb_pkg::PROD_W'($signed(r_s0_taps[(3*a+b)*c3rb_pkg::PIX_W +:
                                                        c3rb_pkg::PIX_W])) *
                    c3rb_pkg::PROD_W'($signed(i_kernel[a][b*c3rb_pkg::COEF_SLOT_W +:
                                                          c3rb_pkg::COEF_W]));
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_row[a] = c3rb_pkg::RSUM_W'(r_s1_prod[3*a])
                     + c3rb_pkg::RSUM_W'(r_s1_prod[3*a+1])
                     + c3rb_pkg::RSUM_W'(r_s1_prod[3*a+2]);
        end
        n_sum = c3rb_pkg::SUM_W'(r_s2_row[0]) + c3rb_pkg::SUM_W'(r_s2_row[1])
              + c3rb_pkg::SUM_W'(r_s2_row[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl.valid <= 1'b0;
            r_s1_ctl.valid <= 1'b0;
            r_s2_ctl.valid <= 1'b0;
            r_s3_ctl.valid <= 1'b0;
        end else begin
            r_s0_ctl.valid <= i_ctl.valid;
            r_s1_ctl.valid <= r_s0_ctl.valid;
            r_s2_ctl.valid <= r_s1_ctl.valid;
            r_s3_ctl.valid <= r_s2_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_ctl.tag <= i_ctl.tag;
        r_s0_taps    <= i_taps;
        r_s1_ctl.tag <= r_s0_ctl.tag;
        r_s1_prod    <= n_prod;
        r_s2_ctl.tag <= r_s1_ctl.tag;
        r_s2_row     <= n_row;
        r_s3_ctl.tag <= r_s2_ctl.tag;
        r_s3_value   <= c3rb_pkg::VALUE_W'(n_sum);
    end

    assign o_ctl   = r_s3_ctl;
    assign o_value = r_s3_value;

endmodule

>>> rtl/conv3x3_replicate_border_unit.sv
// Top level of the 3x3 replicate-border convolution block.
// Depends on c3rb_pkg, the channel interfaces in c3rb_ifs.sv and c3rb_mac.
`timescale 1ns / 1ps

// Pixels arrive in raster order on i_in (command pixel) and are kept in a column
// store of MAX_WIDTH words, each word holding the three most recent rows of one
// column; a new pixel costs one read-modify-write of its column word, with the
// word just written forwarded to a read of the same column in the next cycle.
// The block takes one request per cycle while ready is high. A pixel that closes
// a row (from the second row on, width two or more) yields two results and holds
// ready low while the pair sits in stage B, since a single nine-tap
// multiply-accumulate pipeline makes one result per cycle. After the last pixel
// of the frame, drain requests give the bottom row, one result each. Pixels while
// the frame is loaded, and drains before, are absorbed with no result. A
// sixteen-entry result queue keeps requests flowing while the output side stalls,
// and ready drops when that queue could fill or a result pair is pending. The
// store needs no clearing pass after reset. Writing the width or height register
// restarts the frame; registers may only be written while the block is idle.
module conv3x3_replicate_border_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c3rb_in_if.sink     i_in,
    c3rb_cfg_if.sink    i_cfg,
    c3rb_out_if.source  o_out
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [c3rb_pkg::COL_W-1:0]        r_wlast;     // effective width - 1
    logic [c3rb_pkg::ROW_W-1:0]        r_hlast;     // effective height - 1
    c3rb_pkg::t_kernel                 r_kernel;
    logic                              cfg_fire;
    logic                              cfg_restart;
    logic [c3rb_pkg::WIDTH_REG_W-1:0]  cfg_w;
    logic [c3rb_pkg::HEIGHT_REG_W-1:0] cfg_h;
    logic [c3rb_pkg::COL_W-1:0]        n_wlast;
    logic [c3rb_pkg::ROW_W-1:0]        n_hlast;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign cfg_restart = cfg_fire && (i_cfg.index == c3rb_pkg::CFG_IMAGE_WIDTH ||
                                      i_cfg.index == c3rb_pkg::CFG_IMAGE_HEIGHT);
    assign cfg_w = i_cfg.data[c3rb_pkg::WIDTH_REG_W-1:0];
    assign cfg_h = i_cfg.data[c3rb_pkg::HEIGHT_REG_W-1:0];

    // width clamped to 1..MAX_WIDTH, height zero taken as one
    always_comb begin
        if (cfg_w == '0) begin
            n_wlast = '0;
        end else if (int'(cfg_w) > c3rb_pkg::MAX_WIDTH) begin
            n_wlast = c3rb_pkg::COL_W'(c3rb_pkg::MAX_WIDTH - 1);
        end else begin
            n_wlast = c3rb_pkg::COL_W'(cfg_w - 1'b1);
        end
        n_hlast = (cfg_h == '0) ? '0 : c3rb_pkg::ROW_W'(cfg_h - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast  <= '0;
            r_hlast  <= '0;
            r_kernel <= '0;
        end else if (cfg_fire) begin
            case (i_cfg.index)
                c3rb_pkg::CFG_IMAGE_WIDTH:   r_wlast     <= n_wlast;
                c3rb_pkg::CFG_IMAGE_HEIGHT:  r_hlast     <= n_hlast;
                c3rb_pkg::CFG_KERNEL_TOP:    r_kernel[0] <= i_cfg.data[c3rb_pkg::KROW_W-1:0];
                c3rb_pkg::CFG_KERNEL_MIDDLE: r_kernel[1] <= i_cfg.data[c3rb_pkg::KROW_W-1:0];
                c3rb_pkg::CFG_KERNEL_BOTTOM: r_kernel[2] <= i_cfg.data[c3rb_pkg::KROW_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame position and request decode
    // ------------------------------------------------------------------
    logic [c3rb_pkg::ROW_W-1:0] r_in_row;
    logic [c3rb_pkg::COL_W-1:0] r_in_col;
    logic [c3rb_pkg::COL_W-1:0] r_drain_col;
    logic                       r_frame_loaded;
    c3rb_pkg::t_slot            r_slot;         // store slot of r_in_row

    logic in_fire, is_drain, pix_ok, drn_ok, end_row, emit1, emit2;
    logic [1:0]                 n_res;
    logic [c3rb_pkg::USED_W-1:0] r_used;        // results reserved in pipe + queue
    logic b_two;

    assign in_fire  = i_in.valid && i_in.ready;
    assign is_drain = (i_in.command == c3rb_pkg::CMD_DRAIN);
    assign pix_ok   = !is_drain && !r_frame_loaded;
    assign drn_ok   = is_drain && r_frame_loaded;
    assign end_row  = (r_in_col == r_wlast);
    assign emit1    = pix_ok && (r_in_row != '0) && (r_in_col != '0);
    assign emit2    = pix_ok && (r_in_row != '0) && end_row;
    assign n_res    = 2'(emit1) + 2'(emit2) + 2'(drn_ok);

    // a pixel pair in stage B takes the MAC slot of the following cycle too
    assign i_in.ready = !b_two &&
                        (r_used <= c3rb_pkg::USED_W'(c3rb_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_in_row       <= '0;
            r_in_col       <= '0;
            r_drain_col    <= '0;
            r_frame_loaded <= 1'b0;
            r_slot         <= '0;
        end else if (in_fire && pix_ok) begin
            if (end_row) begin
                r_in_col <= '0;
                if (r_in_row == r_hlast) begin
                    r_frame_loaded <= 1'b1;
                    r_drain_col    <= '0;
                end else begin
                    r_in_row <= c3rb_pkg::ROW_W'(r_in_row + 1'b1);
                    r_slot   <= c3rb_pkg::slot_next(r_slot);
                end
            end else begin
                r_in_col <= c3rb_pkg::COL_W'(r_in_col + 1'b1);
            end
        end else if (in_fire && drn_ok) begin
            if (r_drain_col == r_wlast) begin
                // frame done, back to the start
                r_in_row       <= '0;
                r_in_col       <= '0;
                r_drain_col    <= '0;
                r_frame_loaded <= 1'b0;
                r_slot         <= '0;
            end else begin
                r_drain_col <= c3rb_pkg::COL_W'(r_drain_col + 1'b1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: request registered, column words read
    // ------------------------------------------------------------------
    logic                        r_b_valid, r_b_drain, r_b_emit1, r_b_emit2;
    logic                        r_b_lclamp, r_b_c0, r_b_lof;
    c3rb_pkg::t_pix              r_b_pix;
    c3rb_pkg::t_slot             r_b_wslot, r_b_top, r_b_mid, r_b_bot;
    logic [c3rb_pkg::COL_W-1:0]  r_b_addr_a, r_b_addr_b;
    logic [c3rb_pkg::ROW_W-1:0]  r_b_row;
    logic [c3rb_pkg::COL_W-1:0]  n_addr_a, n_addr_b;

    assign n_addr_a = is_drain ? r_drain_col : r_in_col;
    // right neighbour of the drain column, clamped at the last column
    assign n_addr_b = (r_drain_col == r_wlast) ? r_drain_col
                                               : c3rb_pkg::COL_W'(r_drain_col + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= in_fire && (pix_ok || drn_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_b_drain  <= is_drain;
            r_b_pix    <= i_in.pixel[c3rb_pkg::PIX_W-1:0];
            r_b_wslot  <= r_slot;
            r_b_addr_a <= n_addr_a;
            r_b_addr_b <= n_addr_b;
            r_b_emit1  <= emit1;
            r_b_emit2  <= emit2;
            r_b_c0     <= (r_in_col == '0);
            r_b_lof    <= (r_drain_col == r_wlast);
            if (is_drain) begin
                r_b_lclamp <= (r_drain_col == '0);
                r_b_top    <= (r_hlast == '0) ? r_slot : c3rb_pkg::slot_prev(r_slot);
                r_b_mid    <= r_slot;
                r_b_bot    <= r_slot;
                r_b_row    <= r_hlast;
            end else begin
                r_b_lclamp <= (r_in_col == c3rb_pkg::COL_W'(1));
                // second row: the row above the output clamps onto it
                r_b_top    <= (r_in_row == c3rb_pkg::ROW_W'(1)) ?
                              c3rb_pkg::slot_prev(r_slot) : c3rb_pkg::slot_next(r_slot);
                r_b_mid    <= c3rb_pkg::slot_prev(r_slot);
                r_b_bot    <= r_slot;
                r_b_row    <= c3rb_pkg::ROW_W'(r_in_row - 1'b1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Column store: one word per column, read on two ports, written once
    // ------------------------------------------------------------------
    c3rb_pkg::t_colword          r_mem [c3rb_pkg::MAX_WIDTH];
    c3rb_pkg::t_colword          r_rd_a, r_rd_b;
    c3rb_pkg::t_colword          r_fwd_word;
    logic [c3rb_pkg::COL_W-1:0]  r_fwd_addr;
    logic                        r_fwd_v;
    c3rb_pkg::t_colword          word_a, word_b, cur_word;
    logic                        mem_we;

    assign mem_we = r_b_valid && !r_b_drain;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_b_addr_a] <= cur_word;
        end
        r_rd_a <= r_mem[n_addr_a];
        r_rd_b <= r_mem[n_addr_b];
    end

    // the write of the same edge is not seen by the read: forward it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (mem_we) begin
            r_fwd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fwd_addr <= r_b_addr_a;
            r_fwd_word <= cur_word;
        end
    end

    always_comb begin
        word_a = (r_fwd_v && r_fwd_addr == r_b_addr_a) ? r_fwd_word : r_rd_a;
        word_b = (r_fwd_v && r_fwd_addr == r_b_addr_b) ? r_fwd_word : r_rd_b;
        cur_word = word_a;
        if (!r_b_drain) begin
            cur_word[r_b_wslot*c3rb_pkg::PIX_W +: c3rb_pkg::PIX_W] = r_b_pix;
        end
    end

    // ------------------------------------------------------------------
    // Window columns and job forming
    // ------------------------------------------------------------------
    c3rb_pkg::t_colword r_col1, r_col2;     // columns c-1 and c-2
    c3rb_pkg::t_taps    job1_taps, job2_taps, drn_taps;
    c3rb_pkg::t_tag     job1_tag, job2_tag, drn_tag;
    c3rb_pkg::t_taps    r_h_taps;
    c3rb_pkg::t_tag     r_h_tag;
    logic               r_h_valid;
    c3rb_pkg::t_mac_ctl mac_ctl;
    c3rb_pkg::t_taps    mac_taps;

    function automatic c3rb_pkg::t_taps build_taps(
        c3rb_pkg::t_colword l, c3rb_pkg::t_colword c, c3rb_pkg::t_colword r,
        c3rb_pkg::t_slot top, c3rb_pkg::t_slot mid, c3rb_pkg::t_slot bot);
        c3rb_pkg::t_taps    t;
        c3rb_pkg::t_colword cw [3];
        c3rb_pkg::t_slot    sl [3];
        cw[0] = l;   cw[1] = c;   cw[2] = r;
        sl[0] = top; sl[1] = mid; sl[2] = bot;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                t[(3*a+b)*c3rb_pkg::PIX_W +: c3rb_pkg::PIX_W] =
                    cw[b][sl[a]*c3rb_pkg::PIX_W +: c3rb_pkg::PIX_W];
            end
        end
        return t;
    endfunction

    assign b_two = r_b_valid && r_b_emit1 && r_b_emit2;

    always_comb begin
        // output one column left of the pixel
        job1_taps = build_taps(r_b_lclamp ? r_col1 : r_col2, r_col1, cur_word,
                               r_b_top, r_b_mid, r_b_bot);
        // last column of the row: right neighbour clamps onto it
        job2_taps = build_taps(r_b_c0 ? cur_word : r_col1, cur_word, cur_word,
                               r_b_top, r_b_mid, r_b_bot);
        drn_taps  = build_taps(r_b_lclamp ? word_a : r_col1, word_a, word_b,
                               r_b_top, r_b_mid, r_b_bot);

        job1_tag.row           = r_b_row;
        job1_tag.col           = c3rb_pkg::OUT_COL_W'(c3rb_pkg::COL_W'(r_b_addr_a - 1'b1));
        job1_tag.last_in_run   = !r_b_emit2;
        job1_tag.last_of_frame = 1'b0;
        job2_tag.row           = r_b_row;
        job2_tag.col           = c3rb_pkg::OUT_COL_W'(r_b_addr_a);
        job2_tag.last_in_run   = 1'b1;
        job2_tag.last_of_frame = 1'b0;
        drn_tag.row            = r_b_row;
        drn_tag.col            = c3rb_pkg::OUT_COL_W'(r_b_addr_a);
        drn_tag.last_in_run    = 1'b1;
        drn_tag.last_of_frame  = r_b_lof;
    end

    always_comb begin
        mac_ctl.valid = 1'b0;
        mac_ctl.tag   = job1_tag;
        mac_taps      = job1_taps;
        if (r_h_valid) begin
            mac_ctl.valid = 1'b1;
            mac_ctl.tag   = r_h_tag;
            mac_taps      = r_h_taps;
        end else if (r_b_valid && r_b_drain) begin
            mac_ctl.valid = 1'b1;
            mac_ctl.tag   = drn_tag;
            mac_taps      = drn_taps;
        end else if (r_b_valid && r_b_emit1) begin
            mac_ctl.valid = 1'b1;
        end else if (r_b_valid && r_b_emit2) begin
            mac_ctl.valid = 1'b1;
            mac_ctl.tag   = job2_tag;
            mac_taps      = job2_taps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else begin
            r_h_valid <= b_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_two) begin
            r_h_taps <= job2_taps;
            r_h_tag  <= job2_tag;
        end
        if (r_b_valid) begin
            if (r_b_drain) begin
                r_col1 <= word_a;
            end else begin
                r_col2 <= r_col1;
                r_col1 <= cur_word;
            end
        end
    end

    // ------------------------------------------------------------------
    // Multiply-accumulate and result queue
    // ------------------------------------------------------------------
    c3rb_pkg::t_mac_ctl                  res_ctl;
    logic signed [c3rb_pkg::VALUE_W-1:0] res_value;
    c3rb_pkg::t_result                   r_fifo [c3rb_pkg::FIFO_DEPTH];
    c3rb_pkg::t_result                   head;
    logic [c3rb_pkg::FIFO_AW-1:0]        r_wp, r_rp;
    logic [c3rb_pkg::USED_W-1:0]         r_cnt;
    logic                                pop;

    c3rb_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_taps   (mac_taps),
        .i_kernel (r_kernel),
        .o_ctl    (res_ctl),
        .o_value  (res_value)
    );

    assign pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (res_ctl.valid) begin
            r_fifo[r_wp] <= '{value: res_value, tag: res_ctl.tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_used <= '0;
        end else begin
            if (res_ctl.valid) begin
                r_wp <= c3rb_pkg::FIFO_AW'(r_wp + 1'b1);
            end
            if (pop) begin
                r_rp <= c3rb_pkg::FIFO_AW'(r_rp + 1'b1);
            end
            r_cnt  <= c3rb_pkg::USED_W'(r_cnt + c3rb_pkg::USED_W'(res_ctl.valid)
                                        - c3rb_pkg::USED_W'(pop));
            r_used <= c3rb_pkg::USED_W'(r_used
                                        + (in_fire ? c3rb_pkg::USED_W'(n_res) : '0)
                                        - c3rb_pkg::USED_W'(pop));
        end
    end

    assign head                = r_fifo[r_rp];
    assign o_out.valid         = (r_cnt != '0);
    assign o_out.value         = head.value;
    assign o_out.out_row       = head.tag.row;
    assign o_out.out_col       = head.tag.col;
    assign o_out.last_in_run   = head.tag.last_in_run;
    assign o_out.last_of_frame = head.tag.last_of_frame;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= c3rb_pkg::USED_W'(c3rb_pkg::FIFO_DEPTH))
        else $error("result reservations exceed queue depth");

    a_queue_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_used)
        else $error("queue holds a result that was never reserved");

    a_hold_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_h_valid |-> !r_b_valid)
        else $error("second result of a pair collides with a new request");

    a_pair_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_two |-> !i_in.ready)
        else $error("request taken while a result pair is pending");

    a_size_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_restart |=> (!r_frame_loaded && r_in_col == '0 && r_in_row == '0))
        else $error("size write did not restart the frame");

endmodule
